[rtl/rsde_pkg.sv]
package rsde_pkg;

	localparam int XLEN        = 32;
	localparam int REG_IDX_W   = 5;
	localparam int IN_DATA_W   = 4 * XLEN;
	localparam int OUT_FIELDS_W = 4 * XLEN + REG_IDX_W + 5;
	localparam int OUT_DATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELDS_W;
	localparam int OUT_USER_W  = 2;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_JAL    = 7'h6F;
	localparam logic [6:0] OP_JALR   = 7'h67;
	localparam logic [6:0] OP_REG    = 7'h33;
	localparam logic [6:0] OP_IMM    = 7'h13;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_LUI    = 7'h37;
	localparam logic [6:0] OP_AUIPC  = 7'h17;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;
	localparam logic [2:0] F3_WORD = 3'd2;
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_JALR = 3'd0;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_SUB  = 7'h20;
	localparam logic [6:0] F7_MUL  = 7'h01;

	localparam logic [XLEN-1:0] END_WORD = 32'hFFFF_FFFF;

	typedef enum logic [4:0] {
		K_BUBBLE,
		K_NONE,
		K_ADD,
		K_SUB,
		K_MUL,
		K_AND,
		K_OR,
		K_ADDI,
		K_ANDI,
		K_ORI,
		K_LW,
		K_SW,
		K_LUI,
		K_AUIPC,
		K_BEQ,
		K_JAL,
		K_JALR
	} op_kind_t;

	// Classified instruction handed from the decoder to the execute side.
	typedef struct packed {
		op_kind_t              kind;
		logic                  prog_end;
		logic [REG_IDX_W-1:0]  rd;
		logic [XLEN-1:0]       imm;
		logic [XLEN-1:0]       pc;
		logic [XLEN-1:0]       src1;
		logic [XLEN-1:0]       src2;
	} dec_t;

	typedef struct packed {
		logic                  bubble;
		logic                  program_end;
		logic                  rd_write;
		logic [REG_IDX_W-1:0]  dest_index;
		logic [XLEN-1:0]       write_value;
		logic                  load_request;
		logic                  store_request;
		logic [XLEN-1:0]       mem_address;
		logic [XLEN-1:0]       store_data;
		logic                  control_transfer;
		logic                  taken;
		logic [XLEN-1:0]       next_target;
	} res_t;

endpackage

[rtl/rsde_front.sv]
module rsde_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rsde_pkg::IN_DATA_W-1:0] in_data,
	output logic                          push_valid,
	input  logic                          push_ready,
	output rsde_pkg::dec_t                push_data
);
	import rsde_pkg::*;

	logic [XLEN-1:0] word;
	logic [6:0]      opcode;
	logic [2:0]      f3;
	logic [6:0]      f7;
	logic [XLEN-1:0] imm_i, imm_s, imm_b, imm_u, imm_j;
	op_kind_t        kind;
	logic [XLEN-1:0] imm;
	logic            valid_s1;
	dec_t            dec_s1;

	assign word   = in_data[XLEN-1:0];
	assign opcode = word[6:0];
	assign f3     = word[14:12];
	assign f7     = word[31:25];

	assign imm_i = {{20{word[31]}}, word[31:20]};
	assign imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
	assign imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
	assign imm_u = {word[31:12], 12'b0};
	assign imm_j = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};

	always_comb begin
		kind = K_NONE;
		case (opcode)
			OP_REG: begin
				if (f3 == F3_ADD && f7 == F7_BASE)     kind = K_ADD;
				else if (f3 == F3_ADD && f7 == F7_SUB) kind = K_SUB;
				else if (f3 == F3_ADD && f7 == F7_MUL) kind = K_MUL;
				else if (f3 == F3_AND && f7 == F7_BASE) kind = K_AND;
				else if (f3 == F3_OR && f7 == F7_BASE)  kind = K_OR;
			end
			OP_IMM: begin
				if (f3 == F3_ADD)      kind = K_ADDI;
				else if (f3 == F3_AND) kind = K_ANDI;
				else if (f3 == F3_OR)  kind = K_ORI;
			end
			OP_LOAD: begin
				if (f3 == F3_WORD) kind = K_LW;
			end
			OP_STORE: begin
				if (f3 == F3_WORD) kind = K_SW;
			end
			OP_LUI:   kind = K_LUI;
			OP_AUIPC: kind = K_AUIPC;
			OP_BRANCH: begin
				if (f3 == F3_BEQ) kind = K_BEQ;
			end
			OP_JAL: kind = K_JAL;
			OP_JALR: begin
				if (f3 == F3_JALR) kind = K_JALR;
			end
			default: kind = K_BUBBLE;
		endcase
		if (word == '0 || word == END_WORD) begin
			kind = K_BUBBLE;
		end
	end

	always_comb begin
		case (kind)
			K_ADDI, K_ANDI, K_ORI, K_LW, K_JALR: imm = imm_i;
			K_SW:                                imm = imm_s;
			K_BEQ:                               imm = imm_b;
			K_LUI, K_AUIPC:                      imm = imm_u;
			K_JAL:                               imm = imm_j;
			default:                             imm = '0;
		endcase
	end

	// The decode register advances whenever it is empty or its beat moves on.
	assign in_ready = !valid_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			dec_s1.kind     <= kind;
			dec_s1.prog_end <= (word == END_WORD);
			dec_s1.rd       <= word[11:7];
			dec_s1.imm      <= imm;
			dec_s1.pc       <= in_data[2*XLEN-1:XLEN];
			dec_s1.src1     <= in_data[3*XLEN-1:2*XLEN];
			dec_s1.src2     <= in_data[4*XLEN-1:3*XLEN];
		end
	end

	assign push_valid = valid_s1;
	assign push_data  = dec_s1;

endmodule

[rtl/rsde_queue.sv]
module rsde_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  rsde_pkg::dec_t push_data,
	output logic           pop_valid,
	input  logic           pop_ready,
	output rsde_pkg::dec_t pop_data
);
	import rsde_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	dec_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL_CNT)
		else $error("queue holds more entries than its depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a lone push");

endmodule

[rtl/rsde_back.sv]
module rsde_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pop_valid,
	output logic                             pop_ready,
	input  rsde_pkg::dec_t                   pop_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output rsde_pkg::res_t                   out_res
);
	import rsde_pkg::*;

	logic [XLEN-1:0]   a, b, imm, pc;
	logic [XLEN-1:0]   pc4, a_imm, pc_imm;
	logic [XLEN-1:0]   product;
	logic              writes;
	res_t              res;
	logic              valid_q;
	res_t              res_q;

	assign a      = pop_data.src1;
	assign b      = pop_data.src2;
	assign imm    = pop_data.imm;
	assign pc     = pop_data.pc;
	assign pc4    = pc + XLEN'(4);
	assign a_imm  = a + imm;
	assign pc_imm = pc + imm;
	assign product = a * b;

	always_comb begin
		res = '0;
		writes = 1'b0;
		res.next_target = pc4;
		res.dest_index  = pop_data.rd;
		case (pop_data.kind)
			K_BUBBLE: begin
				res = '0;
				res.bubble      = 1'b1;
				res.program_end = pop_data.prog_end;
			end
			K_ADD:   begin writes = 1'b1; res.write_value = a + b; end
			K_SUB:   begin writes = 1'b1; res.write_value = a - b; end
			K_MUL:   begin writes = 1'b1; res.write_value = product; end
			K_AND:   begin writes = 1'b1; res.write_value = a & b; end
			K_OR:    begin writes = 1'b1; res.write_value = a | b; end
			K_ADDI:  begin writes = 1'b1; res.write_value = a_imm; end
			K_ANDI:  begin writes = 1'b1; res.write_value = a & imm; end
			K_ORI:   begin writes = 1'b1; res.write_value = a | imm; end
			K_LW: begin
				writes = 1'b1;
				res.load_request = 1'b1;
				res.mem_address  = {a_imm[XLEN-1:2], 2'b00};
			end
			K_SW: begin
				res.store_request = 1'b1;
				res.mem_address   = {a_imm[XLEN-1:2], 2'b00};
				res.store_data    = b;
			end
			K_LUI:   begin writes = 1'b1; res.write_value = imm; end
			K_AUIPC: begin writes = 1'b1; res.write_value = pc_imm; end
			K_BEQ: begin
				res.control_transfer = 1'b1;
				res.taken            = (a == b);
				res.next_target      = (a == b) ? pc_imm : pc4;
			end
			K_JAL: begin
				writes = 1'b1;
				res.write_value      = pc4;
				res.control_transfer = 1'b1;
				res.taken            = 1'b1;
				res.next_target      = pc_imm;
			end
			K_JALR: begin
				writes = 1'b1;
				res.write_value      = pc4;
				res.control_transfer = 1'b1;
				res.taken            = 1'b1;
				res.next_target      = {a_imm[XLEN-1:1], 1'b0};
			end
			default: ;
		endcase
		res.rd_write = writes && (pop_data.rd != '0);
	end

	// The output register takes a new beat while the previous one leaves.
	assign pop_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop_ready) begin
			valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && res_q.bubble) |-> (!res_q.rd_write && !res_q.load_request &&
			!res_q.store_request && !res_q.control_transfer))
		else $error("bubble carries an action");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (!(res_q.load_request && res_q.store_request) &&
			(!res_q.taken || res_q.control_transfer)))
		else $error("conflicting result flags");

endmodule

[rtl/rv32_subset_decode_execute.sv]
// Channel  Direction  Beat contents
// s_axis   in         tdata: instr_word, instr_addr, src1_value, src2_value
// m_axis   out        tdata: register write, memory request and branch outcome;
//                     tuser: bubble, program_end
//
// One beat is accepted per cycle while s_axis_tready is high; its result passes
// through the decode register, a queue entry, then the execute output register.
// A two-entry queue between decode and execute lets either side stall on its own.
// The execute stage holds one 32x32 multiplier, a few 32-bit adders and a compare.
// Reset clears only valid flags, queue pointers and count; there is no clearing pass.
module rv32_subset_decode_execute (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// instr_word [31:0], instr_addr [63:32], src1_value [95:64], src2_value [127:96]
	input  logic [rsde_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// rd_write, dest_index, write_value, load_request, store_request, mem_address,
	// store_data, control_transfer, taken, next_target, zero fill
	output logic [rsde_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// bubble, program_end
	output logic [rsde_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
	import rsde_pkg::*;

	logic push_valid, push_ready, pop_valid, pop_ready;
	dec_t push_data, pop_data;
	res_t res;

	rsde_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	rsde_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	rsde_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {
		{OUT_PAD_W{1'b0}},
		res.next_target,
		res.taken,
		res.control_transfer,
		res.store_data,
		res.mem_address,
		res.store_request,
		res.load_request,
		res.write_value,
		res.dest_index,
		res.rd_write
	};

	assign m_axis_tuser = {res.program_end, res.bubble};

endmodule
